// ----- rtl/postfix_stack_evaluator_macros.svh -----
// ----------------------------------------------------------------------------
// postfix stack evaluator assertion macros
// shared property forms for the checker of the postfix stack evaluator
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// same-cycle implication, off while reset is high
`define PSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("postfix stack evaluator check failed");

// next-cycle implication, off while reset is high
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("postfix stack evaluator check failed");

// next-cycle implication that also holds across reset
`define PSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("postfix stack evaluator check failed");

`endif

// ----- rtl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// shared widths, codes and token command type of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

   // operand stack and datapath sizes
   localparam int STACK_DEPTH = 64;
   localparam int DEPTH_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int PTR_WIDTH   = $clog2(STACK_DEPTH);
   localparam int DATA_WIDTH  = 32;
   localparam int DIGIT_WIDTH = 4;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

   // token queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // stream widths
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 40;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_DIV_ZERO  = 2'd3
   } status_type;

   // classified token as it travels from front to back
   typedef struct packed {
      logic                   is_push;
      logic [DIGIT_WIDTH-1:0] digit;
      opcode_type             opcode;
      logic                   last;
   } token_cmd_type;

endpackage

// ----- rtl/pse_front.sv -----
// ----------------------------------------------------------------------------
// pse_front
// accepts tokens, classifies them and holds them in a short queue for the back
// ----------------------------------------------------------------------------
module pse_front
   import pse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   output logic                      cmd_valid,
   input  logic                      cmd_pop,
   output token_cmd_type             cmd
);

   token_cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]     count_ff, count_in;
   token_cmd_type             token;
   logic                      push;
   logic                      pop;

   // classify the incoming token
   always_comb begin
      token.is_push = ~req_tuser;
      token.digit   = req_tdata[DIGIT_WIDTH-1:0];
      token.opcode  = opcode_type'(req_tdata[DIGIT_WIDTH+1:DIGIT_WIDTH]);
      token.last    = req_tlast;
   end

   assign req_tready = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop & cmd_valid;
   assign cmd        = queue_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= token;
      end
   end

endmodule

// ----- rtl/pse_divider.sv -----
// ----------------------------------------------------------------------------
// pse_divider
// iterative signed divider, one quotient bit a cycle, truncating toward zero
// ----------------------------------------------------------------------------
module pse_divider
   import pse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   neg_ff, neg_in;
   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]  quo_ff, quo_in;
   logic [DATA_WIDTH-1:0]  div_ff, div_in;
   logic [DATA_WIDTH:0]    shifted;
   logic [DATA_WIDTH:0]    diff;
   logic                   dividend_neg;
   logic                   divisor_neg;

   assign dividend_neg = dividend[DATA_WIDTH-1];
   assign divisor_neg  = divisor[DATA_WIDTH-1];

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         neg_in   = dividend_neg ^ divisor_neg;
         rem_in   = '0;
         quo_in   = dividend_neg ? (~dividend + 1'b1) : dividend;
         div_in   = divisor_neg ? (~divisor + 1'b1) : divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
         end
         quo_in   = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
         count_in = count_ff + 1'b1;
         if (count_ff == COUNT_WIDTH'(DATA_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   // sign fix of the magnitude quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ----- rtl/pse_back.sv -----
// ----------------------------------------------------------------------------
// pse_back
// executes queued tokens on the operand stack and registers the result
// ----------------------------------------------------------------------------
module pse_back
   import pse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   input  token_cmd_type             cmd,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_OPERATE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type               state_ff;
   token_cmd_type           cmd_ff;
   logic [DATA_WIDTH-1:0]   tos_ff;
   logic [DEPTH_WIDTH-1:0]  depth_ff;
   status_type              err_ff;
   logic                    rsp_valid_ff;
   logic [DATA_WIDTH-1:0]   rsp_value_ff;
   status_type              rsp_status_ff;

   // stack entries below the top; the top itself lives in tos_ff
   logic [DATA_WIDTH-1:0]   stack_mem [STACK_DEPTH];
   logic [DATA_WIDTH-1:0]   rd_data_ff;
   logic                    wr_en;
   logic [PTR_WIDTH-1:0]    wr_addr;
   logic [PTR_WIDTH-1:0]    rd_addr;
   logic [DEPTH_WIDTH-1:0]  depth_minus_one;
   logic [DEPTH_WIDTH-1:0]  depth_minus_two;

   logic                    div_start;
   logic                    div_done;
   logic [DATA_WIDTH-1:0]   div_quotient;
   logic [DATA_WIDTH-1:0]   alu_result;
   logic                    stack_full;
   logic                    out_free;
   status_type              final_status;

   assign depth_minus_one = depth_ff - DEPTH_WIDTH'(1);
   assign depth_minus_two = depth_ff - DEPTH_WIDTH'(2);
   assign wr_addr         = depth_minus_one[PTR_WIDTH-1:0];
   assign rd_addr         = depth_minus_two[PTR_WIDTH-1:0];
   assign stack_full      = (depth_ff >= DEPTH_WIDTH'(STACK_DEPTH));
   assign out_free        = ~rsp_valid_ff | rsp_tready;

   // spill the old top when a digit is pushed onto a non-empty stack
   assign wr_en = (state_ff == S_APPLY) && (err_ff == STATUS_OK) && cmd_ff.is_push &&
                  !stack_full && (depth_ff != '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= tos_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // add, subtract and low word of the product; left operand is below the top
   always_comb begin
      case (cmd_ff.opcode)
         OP_ADD:  alu_result = rd_data_ff + tos_ff;
         OP_SUB:  alu_result = rd_data_ff - tos_ff;
         default: alu_result = rd_data_ff * tos_ff;
      endcase
   end

   assign div_start = (state_ff == S_OPERATE) && (cmd_ff.opcode == OP_DIV) &&
                      (tos_ff != '0);

   pse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // status reported on the last token
   always_comb begin
      if (err_ff != STATUS_OK) begin
         final_status = err_ff;
      end else if (depth_ff == '0) begin
         final_status = STATUS_UNDERFLOW;
      end else begin
         final_status = STATUS_OK;
      end
   end

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   // token sequencer with stack control and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken and no new one loaded in the same cycle
         if (rsp_valid_ff && rsp_tready && !(state_ff == S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               state_ff <= cmd_ff.last ? S_FINISH : S_IDLE;
               if (err_ff == STATUS_OK) begin
                  if (cmd_ff.is_push) begin
                     if (stack_full) begin
                        err_ff <= STATUS_OVERFLOW;
                     end else begin
                        tos_ff   <= {{(DATA_WIDTH-DIGIT_WIDTH){1'b0}}, cmd_ff.digit};
                        depth_ff <= depth_ff + 1'b1;
                     end
                  end else if (depth_ff < DEPTH_WIDTH'(2)) begin
                     err_ff <= STATUS_UNDERFLOW;
                  end else begin
                     state_ff <= S_OPERATE;
                  end
               end
            end
            S_OPERATE: begin
               if (cmd_ff.opcode == OP_DIV) begin
                  if (tos_ff == '0) begin
                     err_ff   <= STATUS_DIV_ZERO;
                     state_ff <= cmd_ff.last ? S_FINISH : S_IDLE;
                  end else begin
                     state_ff <= S_DIVIDE;
                  end
               end else begin
                  tos_ff   <= alu_result;
                  depth_ff <= depth_minus_one;
                  state_ff <= cmd_ff.last ? S_FINISH : S_IDLE;
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  tos_ff   <= div_quotient;
                  depth_ff <= depth_minus_one;
                  state_ff <= cmd_ff.last ? S_FINISH : S_IDLE;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= final_status;
                  rsp_value_ff  <= (final_status == STATUS_OK) ? tos_ff : '0;
                  depth_ff      <= '0;
                  err_ff        <= STATUS_OK;
                  state_ff      <= S_IDLE;
               end else begin
                  rsp_valid_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-DATA_WIDTH-2){1'b0}}, rsp_status_ff, rsp_value_ff};

endmodule

// ----- rtl/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// evaluates postfix expressions token by token on a 64-entry operand stack
// ----------------------------------------------------------------------------
// channel  direction  fields (tdata from bit 0 up)
// req      in         tdata: digit[3:0], opcode[5:4]; tuser: is_operator; tlast
// rsp      out        tdata: value[31:0], status[33:32]
//
// a digit passes through idle and apply, add, subtract or multiply also through operate,
// divide waits on the one-bit-a-cycle divider; a last token passes finish for the result
// a queue of four tokens lets the input keep being taken while the back works
// or while a result waits on rsp_tready
// synchronous active-high reset empties the queue, the stack and the error
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
   import pse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // digit[3:0], opcode[5:4], zero[7:6]
   input  logic                      req_tuser,  // is_operator
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata   // value[31:0], status[33:32], zero[39:34]
);

   logic          cmd_valid;
   logic          cmd_pop;
   token_cmd_type cmd;

   // token intake and queue
   pse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   // stack execution and result
   pse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/pse_checker.sv -----
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks of the postfix stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_macros.svh"

module pse_checker
   import pse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tready,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   status_type rsp_status;
   logic       rsp_value_zero;

   assign rsp_status     = status_type'(rsp_tdata[DATA_WIDTH+1:DATA_WIDTH]);
   assign rsp_value_zero = (rsp_tdata[DATA_WIDTH-1:0] == '0);

   // after reset the queue is empty and no result is pending
   `PSE_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, req_tready && !rsp_tvalid)

   // a failed expression reports a zero value
   `PSE_ASSERT_IMPLY(a_error_value_zero, clock, reset,
                     rsp_tvalid && rsp_status != STATUS_OK, rsp_value_zero)

   // padding above the status stays zero
   `PSE_ASSERT_IMPLY(a_rsp_pad_zero, clock, reset, rsp_tvalid,
                     rsp_tdata[RSP_DATA_WIDTH-1:DATA_WIDTH+2] == '0)

   // a stalled result holds
   `PSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/postfix_stack_evaluator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb
// self-checking bench for the postfix stack evaluator: a directed token table,
// then random expressions, deep stacks, wrapping chains and noise, each result
// transfer checked against the table's expected value or a behavioural copy of the evaluator
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_tb;
   import pse_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned RANDOM_TOKENS = 1400;
   localparam int unsigned DRAIN_CYCLES  = 64;
   localparam int unsigned HOLD_OFF      = 400;

   // one expected result transfer
   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      status_type            status;
   } outcome_type;

   // one row of the directed table
   typedef struct packed {
      logic                   is_op;
      logic [DIGIT_WIDTH-1:0] dig;
      opcode_type             op;
      logic                   last;
      logic                   typed;
      logic [DATA_WIDTH-1:0]  value;
      status_type             status;
   } token_row_type;

   localparam int NUM_ROWS = 26;
   localparam token_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      // operator as the only token after reset: nothing to pop
      '{1'b1, 4'd0,  OP_ADD, 1'b1, 1'b1, 32'd0,          STATUS_UNDERFLOW},
      // single digits, the largest legal one and one above nine
      '{1'b0, 4'd9,  OP_ADD, 1'b1, 1'b1, 32'd9,          STATUS_OK},
      '{1'b0, 4'd15, OP_ADD, 1'b1, 1'b1, 32'd15,         STATUS_OK},
      // zero over zero
      '{1'b0, 4'd0,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd0,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_DIV, 1'b1, 1'b1, 32'd0,          STATUS_DIV_ZERO},
      // operand order: 3 - 7
      '{1'b0, 4'd3,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd7,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_SUB, 1'b1, 1'b1, 32'hFFFF_FFFC,  STATUS_OK},
      // largest digit product
      '{1'b0, 4'd15, OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd15, OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_MUL, 1'b1, 1'b1, 32'd225,        STATUS_OK},
      // (0 - 7) / 2 truncates toward zero
      '{1'b0, 4'd0,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd7,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_SUB, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd2,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_DIV, 1'b1, 1'b1, 32'hFFFF_FFFD,  STATUS_OK},
      // plain add, left to the predictor
      '{1'b0, 4'd9,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd6,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_ADD, 1'b1, 1'b0, 32'd0,          STATUS_OK},
      // underflow, then tokens that must be ignored until the last one
      '{1'b0, 4'd5,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd4,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b1, 4'd0,  OP_MUL, 1'b1, 1'b1, 32'd0,          STATUS_UNDERFLOW},
      // entry left below the top is dropped
      '{1'b0, 4'd1,  OP_ADD, 1'b0, 1'b0, 32'd0,          STATUS_OK},
      '{1'b0, 4'd2,  OP_ADD, 1'b1, 1'b1, 32'd2,          STATUS_OK}
   };

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;  // digit[3:0], opcode[5:4], zero[7:6]
   logic                      req_tuser  = 1'b0; // is_operator
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;  // value[31:0], status[33:32], zero[39:34]

   // evaluator copy kept by the bench
   logic [DATA_WIDTH-1:0] model_stack [STACK_DEPTH];
   int unsigned           model_depth = 0;
   status_type            model_error = STATUS_OK;

   outcome_type pending_results [$];
   int unsigned tokens_applied = 0;
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;
   bit          steady         = 1'b0;

   postfix_stack_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // signed quotient truncated toward zero, wrapping for the most negative value
   function automatic logic [DATA_WIDTH-1:0] signed_quotient(
      input logic [DATA_WIDTH-1:0] num,
      input logic [DATA_WIDTH-1:0] den
   );
      logic [DATA_WIDTH-1:0] mag_num;
      logic [DATA_WIDTH-1:0] mag_den;
      logic [DATA_WIDTH-1:0] quo;
      mag_num = num[DATA_WIDTH-1] ? (32'd0 - num) : num;
      mag_den = den[DATA_WIDTH-1] ? (32'd0 - den) : den;
      quo     = mag_num / mag_den;
      return (num[DATA_WIDTH-1] != den[DATA_WIDTH-1]) ? (32'd0 - quo) : quo;
   endfunction

   // applies one token to the bench copy; returns 1 with the result on a last token
   function automatic bit evaluate_token(
      input  logic                   is_op,
      input  logic [DIGIT_WIDTH-1:0] dig,
      input  opcode_type             op,
      input  logic                   last,
      output outcome_type            outcome
   );
      logic [DATA_WIDTH-1:0] lhs;
      logic [DATA_WIDTH-1:0] rhs;
      logic [DATA_WIDTH-1:0] res;
      outcome = '0;
      res     = '0;
      if (model_error == STATUS_OK) begin
         tokens_applied++;
         if (!is_op) begin
            if (model_depth >= STACK_DEPTH) begin
               model_error = STATUS_OVERFLOW;
            end else begin
               model_stack[model_depth] = 32'(dig);
               model_depth++;
            end
         end else if (model_depth < 2) begin
            model_error = STATUS_UNDERFLOW;
         end else begin
            rhs = model_stack[model_depth-1];
            lhs = model_stack[model_depth-2];
            case (op)
               OP_ADD: res = lhs + rhs;
               OP_SUB: res = lhs - rhs;
               OP_MUL: res = lhs * rhs;
               default: begin
                  if (rhs == '0) model_error = STATUS_DIV_ZERO;
                  else res = signed_quotient(lhs, rhs);
               end
            endcase
            if (model_error == STATUS_OK) begin
               model_depth--;
               model_stack[model_depth-1] = res;
            end
         end
      end
      if (!last) return 1'b0;
      // close the expression and clear the stack and the error
      outcome.status = model_error;
      if (outcome.status == STATUS_OK && model_depth == 0) outcome.status = STATUS_UNDERFLOW;
      if (outcome.status == STATUS_OK) outcome.value = model_stack[model_depth-1];
      model_depth = 0;
      model_error = STATUS_OK;
      return 1'b1;
   endfunction

   // offers one token, waits for its transfer and records what it should cause
   task automatic send_token(
      input logic                   is_op,
      input logic [DIGIT_WIDTH-1:0] dig,
      input opcode_type             op,
      input logic                   last,
      input bit                     typed        = 1'b0,
      input logic [DATA_WIDTH-1:0]  typed_value  = '0,
      input status_type             typed_status = STATUS_OK
   );
      int unsigned gap;
      outcome_type predicted;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, op, dig};
      req_tuser  <= is_op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (evaluate_token(is_op, dig, op, last, predicted)) begin
         if (typed) begin
            predicted.value  = typed_value;
            predicted.status = typed_status;
         end
         pending_results.push_back(predicted);
      end
   endtask

   // digits mostly legal, now and then above nine
   function automatic logic [DIGIT_WIDTH-1:0] pick_digit();
      if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
      return 4'($urandom_range(0, 9));
   endfunction

   // operators with extra weight on multiply so values grow large
   function automatic opcode_type pick_operator();
      int unsigned r;
      r = $urandom_range(0, 5);
      if (r > 3) return OP_MUL;
      return opcode_type'(r);
   endfunction

   // well-formed expression, sometimes leaving spare entries below the top
   task automatic send_expression();
      int unsigned operands;
      int unsigned operators;
      int unsigned spare;
      int unsigned height;
      logic        last;
      operands = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      spare    = (operands > 1 && $urandom_range(0, 7) == 0) ?
                 $urandom_range(1, operands - 1) : 0;
      operators = operands - 1 - spare;
      height    = 0;
      while (operands + operators > 0) begin
         last = (operands + operators == 1);
         if (operands > 0 && (height < 2 || operators == 0 || $urandom_range(0, 1) == 0)) begin
            send_token(1'b0, pick_digit(), opcode_type'($urandom_range(0, 3)), last);
            operands--;
            height++;
         end else begin
            send_token(1'b1, 4'($urandom), pick_operator(), last);
            operators--;
            height--;
         end
      end
   endtask

   // pushes around the stack size, so a full stack and a push past it both occur
   task automatic send_deep_stack();
      int unsigned pushes;
      pushes = ($urandom_range(0, 1) == 0) ? STACK_DEPTH + 1 : $urandom_range(62, 68);
      for (int unsigned i = 1; i <= pushes; i++)
         send_token(1'b0, pick_digit(), opcode_type'($urandom_range(0, 3)), i == pushes);
   endtask

   // powers of two by repeated multiply, then divided by minus one
   task automatic send_wrap_chain();
      int unsigned doublings;
      doublings = ($urandom_range(0, 1) == 0) ? 30 : $urandom_range(28, 31);
      send_token(1'b0, 4'd2, OP_ADD, 1'b0);
      repeat (doublings) begin
         send_token(1'b0, 4'd2, OP_ADD, 1'b0);
         send_token(1'b1, 4'($urandom), OP_MUL, 1'b0);
      end
      send_token(1'b0, 4'd0, OP_ADD, 1'b0);
      send_token(1'b0, 4'd1, OP_ADD, 1'b0);
      send_token(1'b1, 4'($urandom), OP_SUB, 1'b0);
      send_token(1'b1, 4'($urandom), OP_DIV, 1'b1);
   endtask

   // random token mix closed by a last token
   task automatic send_broken();
      int unsigned count;
      count = $urandom_range(1, 8);
      for (int unsigned i = 1; i <= count; i++)
         send_token(1'($urandom), pick_digit(), opcode_type'($urandom_range(0, 3)), i == count);
   endtask

   // result side: random stalls, two long hold-offs, checks each transfer
   initial begin
      int unsigned hold;
      int unsigned taken;
      outcome_type want;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 25 || taken == 90) hold = HOLD_OFF;
         else hold = steady ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, value %h status %0d", $time,
                     rsp_tdata[31:0], rsp_tdata[33:32]);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $display("%0t: value expected %h actual %h", $time, want.value, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[33:32] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tdata[33:32]);
               mismatches++;
            end
         end
      end
   end

   // reset, directed table, random traffic, drain
   initial begin
      int unsigned kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_ROWS; i++)
         send_token(DIRECTED_ROWS[i].is_op, DIRECTED_ROWS[i].dig, DIRECTED_ROWS[i].op,
                    DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].status);

      // random traffic, mostly well-formed expressions
      tokens_applied = 0;
      while (tokens_applied < RANDOM_TOKENS) begin
         steady = ($urandom_range(0, 5) == 0);
         kind   = $urandom_range(0, 99);
         if (kind < 3) send_deep_stack();
         else if (kind < 6) send_wrap_chain();
         else if (kind < 80) send_expression();
         else if (kind < 90) send_broken();
         else send_token(1'($urandom), 4'($urandom), opcode_type'($urandom_range(0, 3)),
                         $urandom_range(0, 3) == 0);
      end
      // close whatever expression is still open
      send_token(1'b0, pick_digit(), OP_ADD, 1'b1);
      req_tvalid <= 1'b0;

      // wait out the remaining results, then a quiet stretch
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
